@@ hw/rtl/clt_pkg.sv @@
package clt_pkg;

    // Store geometry
    localparam int MAX_ITEMS = 256;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);

    // Field widths
    localparam int CNT_W  = 9;
    localparam int CHAR_W = 8;
    localparam int CMD_W  = 4;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = CMD_W + CHAR_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + CHAR_W + CNT_W + CNT_W + 1 + 1 + 4 * CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Capacity register
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(MAX_ITEMS);

    // Tallied byte codes
    localparam logic [CHAR_W-1:0] CHR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHR_T = 8'h54;

    // Cursor value while the list is empty
    localparam logic [CNT_W-1:0] CURSOR_NONE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 4'd0,
        CMD_REMOVE  = 4'd1,
        CMD_REPLACE = 4'd2,
        CMD_CLEAR   = 4'd3,
        CMD_START   = 4'd4,
        CMD_END     = 4'd5,
        CMD_NEXT    = 4'd6,
        CMD_PRIOR   = 4'd7,
        CMD_READ    = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

@@ hw/rtl/clt_ram.sv @@
module clt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/cursor_list_table.sv @@
// Channel  | Dir | Handshake                     | Content
// s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready | command, data_char
// m_axis   | out | o_m_axis_tvalid/i_m_axis_tready | ok, cursor, count, flags, tallies
// cfg      | in  | i_cfg_valid/o_cfg_ready       | capacity_in_use
//
// The store read port is registered: S_IDLE takes an item and issues the read,
// S_EXEC updates and writes back, and no new item is taken in S_EXEC. The
// cursor item is cached in a register, so every command needs at most one read
// followed by one write. Reset (synchronous, active low) empties the list; the
// store itself is not cleared. A stalled result register holds off new items.
module cursor_list_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input items
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [3:0] command, [11:4] data_char, [15:12] zero
    input  logic [clt_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // Result items
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] ok, [8:1] cursor_item, [17:9] cursor_pos, [26:18] item_count,
    // [27] is_empty, [28] is_full, [37:29] count_a, [46:38] count_c,
    // [55:47] count_g, [64:56] count_t, [71:65] zero
    output logic [clt_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // Capacity register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [clt_pkg::CNT_W-1:0]          i_cfg_data
);

    import clt_pkg::*;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [CHAR_W-1:0]  r_char;
    logic [CNT_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_cursor, n_cursor;
    logic [CHAR_W-1:0]  r_cur_item, n_cur_item;
    logic [CNT_W-1:0]   r_tally_a, r_tally_c, r_tally_g, r_tally_t;
    logic [CNT_W-1:0]   n_tally_a, n_tally_c, n_tally_g, n_tally_t;
    logic               r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;

    logic               s_accept;
    t_cmd               s_cmd;
    logic [CNT_W-1:0]   s_last;
    logic               s_empty;
    logic               s_full;
    logic               s_on_last;
    logic [CNT_W-1:0]   s_eff_cap;
    logic [CNT_W-1:0]   s_raddr;
    logic               s_we;
    logic [ADDR_W-1:0]  s_waddr;
    logic [CHAR_W-1:0]  s_wdata;
    logic [CHAR_W-1:0]  s_rdata;
    logic               s_ok;
    logic               s_up, s_dn;
    logic [CHAR_W-1:0]  s_up_ch;
    logic               s_new_empty;
    logic               s_new_full;
    logic [CHAR_W-1:0]  s_out_item;

    // Adjust one tally for an item leaving and an item entering
    function automatic logic [CNT_W-1:0] tally_next(
        input logic [CNT_W-1:0]  tally,
        input logic [CHAR_W-1:0] code,
        input logic              dn,
        input logic [CHAR_W-1:0] dn_ch,
        input logic              up,
        input logic [CHAR_W-1:0] up_ch
    );
        logic [CNT_W-1:0] v;
        v = tally;
        if (dn && (dn_ch == code) && (v != '0)) begin
            v = v - CNT_W'(1);
        end
        if (up && (up_ch == code)) begin
            v = v + CNT_W'(1);
        end
        return v;
    endfunction

    // Status from the current state
    assign s_cmd     = t_cmd'(i_s_axis_tdata[CMD_W-1:0]);
    assign s_eff_cap = (r_cap > CNT_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : r_cap;
    assign s_last    = r_count - CNT_W'(1);
    assign s_empty   = (r_count == '0);
    assign s_full    = (r_count >= s_eff_cap);
    assign s_on_last = (r_cursor == s_last);

    assign o_s_axis_tready = r_state[0] && (!r_m_tvalid || i_m_axis_tready);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Pick the store entry the command needs next
    always_comb begin
        unique case (s_cmd)
            CMD_REMOVE: s_raddr = s_on_last ? (r_cursor - CNT_W'(1)) : s_last;
            CMD_START:  s_raddr = '0;
            CMD_END:    s_raddr = s_last;
            CMD_NEXT:   s_raddr = r_cursor + CNT_W'(1);
            CMD_PRIOR:  s_raddr = r_cursor - CNT_W'(1);
            default:    s_raddr = r_cursor;
        endcase
    end

    clt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_accept),
        .i_raddr (s_raddr[ADDR_W-1:0]),
        .o_rdata (s_rdata)
    );

    // Carry out the latched command and build its result
    always_comb begin
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_cur_item = r_cur_item;
        s_ok       = 1'b0;
        s_we       = 1'b0;
        s_waddr    = r_cursor[ADDR_W-1:0];
        s_wdata    = r_char;
        s_up       = 1'b0;
        s_dn       = 1'b0;
        s_up_ch    = r_char;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (!s_full) begin
                    s_ok       = 1'b1;
                    s_we       = 1'b1;
                    s_waddr    = r_count[ADDR_W-1:0];
                    n_cursor   = r_count;
                    n_count    = r_count + CNT_W'(1);
                    n_cur_item = r_char;
                    s_up       = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!s_empty) begin
                    s_ok       = 1'b1;
                    s_dn       = 1'b1;
                    n_count    = s_last;
                    n_cur_item = s_rdata;
                    if (s_on_last) begin
                        n_cursor = r_cursor - CNT_W'(1);
                    end else begin
                        s_we    = 1'b1;
                        s_wdata = s_rdata;
                    end
                end
            end
            CMD_REPLACE: begin
                if (!s_empty) begin
                    s_ok       = 1'b1;
                    s_we       = 1'b1;
                    s_dn       = 1'b1;
                    s_up       = 1'b1;
                    n_cur_item = r_char;
                end
            end
            CMD_CLEAR: begin
                s_ok     = 1'b1;
                n_count  = '0;
                n_cursor = CURSOR_NONE;
            end
            CMD_START: begin
                if (!s_empty) begin
                    s_ok       = 1'b1;
                    n_cursor   = '0;
                    n_cur_item = s_rdata;
                end
            end
            CMD_END: begin
                if (!s_empty) begin
                    s_ok       = 1'b1;
                    n_cursor   = s_last;
                    n_cur_item = s_rdata;
                end
            end
            CMD_NEXT: begin
                if (!s_empty && !s_on_last) begin
                    s_ok       = 1'b1;
                    n_cursor   = r_cursor + CNT_W'(1);
                    n_cur_item = s_rdata;
                end
            end
            CMD_PRIOR: begin
                if (!s_empty && (r_cursor != '0)) begin
                    s_ok       = 1'b1;
                    n_cursor   = r_cursor - CNT_W'(1);
                    n_cur_item = s_rdata;
                end
            end
            CMD_READ: begin
                s_ok = !s_empty;
            end
            default: begin
                s_ok = 1'b0;
            end
        endcase
        if (!r_state[1]) begin
            s_we = 1'b0;
        end

        if (r_cmd == CMD_CLEAR) begin
            n_tally_a = '0;
            n_tally_c = '0;
            n_tally_g = '0;
            n_tally_t = '0;
        end else begin
            n_tally_a = tally_next(r_tally_a, CHR_A, s_dn, r_cur_item, s_up, s_up_ch);
            n_tally_c = tally_next(r_tally_c, CHR_C, s_dn, r_cur_item, s_up, s_up_ch);
            n_tally_g = tally_next(r_tally_g, CHR_G, s_dn, r_cur_item, s_up, s_up_ch);
            n_tally_t = tally_next(r_tally_t, CHR_T, s_dn, r_cur_item, s_up, s_up_ch);
        end

        s_new_empty = (n_count == '0);
        s_new_full  = (n_count >= s_eff_cap);
        s_out_item  = s_new_empty ? '0 : n_cur_item;
        n_m_tdata   = OUT_TDATA_W'({n_tally_t, n_tally_g, n_tally_c, n_tally_a,
                                    s_new_full, s_new_empty, n_count, n_cursor,
                                    s_out_item, s_ok});
    end

    // Sequence: accept, then execute
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = s_accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and list status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cap      <= CAP_RESET;
            r_count    <= '0;
            r_cursor   <= CURSOR_NONE;
            r_tally_a  <= '0;
            r_tally_c  <= '0;
            r_tally_g  <= '0;
            r_tally_t  <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (r_state[1]) begin
                r_count    <= n_count;
                r_cursor   <= n_cursor;
                r_tally_a  <= n_tally_a;
                r_tally_c  <= n_tally_c;
                r_tally_g  <= n_tally_g;
                r_tally_t  <= n_tally_t;
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Latch the item and hold the result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd  <= s_cmd;
            r_char <= i_s_axis_tdata[CMD_W +: CHAR_W];
        end
        if (r_state[1]) begin
            r_cur_item <= n_cur_item;
            r_m_tdata  <= n_m_tdata;
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

endmodule

@@ dv/cursor_list_table_tb.sv @@
`timescale 1ns / 1ps

module cursor_list_table_tb;
    import clt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    // One status item, laid out as on o_m_axis_tdata (ok in bit 0)
    typedef struct packed {
        logic [CNT_W-1:0]  count_t;
        logic [CNT_W-1:0]  count_g;
        logic [CNT_W-1:0]  count_c;
        logic [CNT_W-1:0]  count_a;
        logic              is_full;
        logic              is_empty;
        logic [CNT_W-1:0]  item_count;
        logic [CNT_W-1:0]  cursor_pos;
        logic [CHAR_W-1:0] cursor_item;
        logic              ok;
    } t_status;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        bit                typed;
        t_status           status;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data;

    cursor_list_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Shadow copy of the list
    logic [CHAR_W-1:0] shadow_items [MAX_ITEMS];
    int                live_n;
    int                cursor;
    int                tally [4];
    int                capacity;

    t_status pending_status [$];
    t_row    dir_rows [$];
    bit      row_typed;
    t_status row_status;
    int      err_count;
    int      quiet_cycles;
    int      src_idle_pct;
    int      sink_stall_pct;
    int      hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Tally slot for a byte, -1 when not tracked
    function automatic int base_slot(input logic [CHAR_W-1:0] ch);
        case (ch)
            CHR_A: return 0;
            CHR_C: return 1;
            CHR_G: return 2;
            CHR_T: return 3;
            default: return -1;
        endcase
    endfunction

    function automatic void bump_tally(input logic [CHAR_W-1:0] ch, input bit up);
        int s;
        s = base_slot(ch);
        if (s < 0) return;
        if (up) tally[s]++;
        else if (tally[s] > 0) tally[s]--;
    endfunction

    // Apply one command to the shadow list and return the status it yields
    function automatic t_status apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                               input logic [CHAR_W-1:0] ch);
        t_status st;
        int      lim;
        int      last;
        logic    done;
        lim  = (capacity > MAX_ITEMS) ? MAX_ITEMS : capacity;
        last = live_n - 1;
        done = 1'b0;
        case (t_cmd'(cmd))
            CMD_INSERT: if (live_n < lim) begin
                shadow_items[live_n] = ch;
                cursor = live_n;
                live_n++;
                bump_tally(ch, 1'b1);
                done = 1'b1;
            end
            CMD_REMOVE: if (live_n != 0) begin
                bump_tally(shadow_items[cursor], 1'b0);
                if (cursor == last) cursor--;
                else shadow_items[cursor] = shadow_items[last];
                live_n--;
                done = 1'b1;
            end
            CMD_REPLACE: if (live_n != 0) begin
                bump_tally(shadow_items[cursor], 1'b0);
                shadow_items[cursor] = ch;
                bump_tally(ch, 1'b1);
                done = 1'b1;
            end
            CMD_CLEAR: begin
                live_n = 0;
                cursor = -1;
                tally  = '{0, 0, 0, 0};
                done   = 1'b1;
            end
            CMD_START: if (live_n != 0) begin
                cursor = 0;
                done = 1'b1;
            end
            CMD_END: if (live_n != 0) begin
                cursor = last;
                done = 1'b1;
            end
            CMD_NEXT: if (live_n != 0 && cursor < last) begin
                cursor++;
                done = 1'b1;
            end
            CMD_PRIOR: if (live_n != 0 && cursor > 0) begin
                cursor--;
                done = 1'b1;
            end
            CMD_READ: done = (live_n != 0);
            default: done = 1'b0;
        endcase
        st.ok          = done;
        st.cursor_item = (live_n == 0) ? '0 : shadow_items[cursor];
        st.cursor_pos  = CNT_W'(cursor);
        st.item_count  = CNT_W'(live_n);
        st.is_empty    = (live_n == 0);
        st.is_full     = (live_n >= lim);
        st.count_a     = CNT_W'(tally[0]);
        st.count_c     = CNT_W'(tally[1]);
        st.count_g     = CNT_W'(tally[2]);
        st.count_t     = CNT_W'(tally[3]);
        return st;
    endfunction

    function automatic t_status mk_status(input logic ok, input logic [CHAR_W-1:0] item,
                                          input logic [CNT_W-1:0] pos, input int cnt,
                                          input logic empty, input logic full,
                                          input int a, input int c, input int g, input int t);
        t_status st;
        st = '{CNT_W'(t), CNT_W'(g), CNT_W'(c), CNT_W'(a), full, empty,
               CNT_W'(cnt), pos, item, ok};
        return st;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    // Predict on accepted commands, check accepted status items, watch for a hang
    always @(posedge i_clk) begin
        t_status want;
        t_status got;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                capacity = int'(i_cfg_data);
                moved = 1'b1;
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                want = apply_list_cmd(i_s_axis_tdata[CMD_W-1:0],
                                      i_s_axis_tdata[CMD_W +: CHAR_W]);
                if (row_typed) want = row_status;
                pending_status.push_back(want);
                moved = 1'b1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_status'(o_m_axis_tdata[OUT_FIELDS_W-1:0]);
                moved = 1'b1;
                if (pending_status.size() == 0) begin
                    $error("status item with nothing expected: %0h", got);
                    err_count++;
                end else begin
                    want = pending_status.pop_front();
                    check_field("ok", CNT_W'(want.ok), CNT_W'(got.ok));
                    check_field("cursor_item", CNT_W'(want.cursor_item),
                                CNT_W'(got.cursor_item));
                    check_field("cursor_pos", want.cursor_pos, got.cursor_pos);
                    check_field("item_count", want.item_count, got.item_count);
                    check_field("is_empty", CNT_W'(want.is_empty), CNT_W'(got.is_empty));
                    check_field("is_full", CNT_W'(want.is_full), CNT_W'(got.is_full));
                    check_field("count_a", want.count_a, got.count_a);
                    check_field("count_c", want.count_c, got.count_c);
                    check_field("count_g", want.count_g, got.count_g);
                    check_field("count_t", want.count_t, got.count_t);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Status receiver: random stalls, or a long hold when asked
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Offer one command and wait until it is taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                             input bit typed, input t_status st);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_TDATA_W'({ch, cmd});
        row_typed  = typed;
        row_status = st;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
    endtask

    // Stop offering and wait for every outstanding status item
    task automatic drain_status();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_capacity(input int value);
        drain_status();
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CNT_W'(value);
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(99) >= 60) return CHAR_W'($urandom_range(255));
        case ($urandom_range(3))
            0: return CHR_A;
            1: return CHR_C;
            2: return CHR_G;
            default: return CHR_T;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input int grow_pct);
        int r;
        if ($urandom_range(99) < grow_pct) return CMD_INSERT;
        r = $urandom_range(99);
        if (r < 14) return CMD_REMOVE;
        if (r < 26) return CMD_REPLACE;
        if (r < 29) return CMD_CLEAR;
        if (r < 36) return CMD_START;
        if (r < 43) return CMD_END;
        if (r < 60) return CMD_NEXT;
        if (r < 77) return CMD_PRIOR;
        if (r < 92) return CMD_READ;
        return CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
    endfunction

    task automatic run_random(input int n, input int grow_pct);
        for (int i = 0; i < n; i++)
            send_item(pick_command(grow_pct), pick_char(), 1'b0, '0);
    endtask

    initial begin
        t_status idle_st;
        live_n          = 0;
        cursor          = -1;
        tally           = '{0, 0, 0, 0};
        capacity        = MAX_ITEMS;
        err_count       = 0;
        quiet_cycles    = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_left       = 0;
        row_typed       = 1'b0;
        row_status      = '0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands; refusals on the empty list are typed in
        idle_st = mk_status(1'b0, 8'h00, CURSOR_NONE, 0, 1'b1, 1'b0, 0, 0, 0, 0);
        dir_rows.push_back('{CMD_READ,    8'h00, 1'b1, idle_st});
        dir_rows.push_back('{CMD_REMOVE,  8'h00, 1'b1, idle_st});
        dir_rows.push_back('{CMD_REPLACE, 8'hFF, 1'b1, idle_st});
        dir_rows.push_back('{CMD_START,   8'h00, 1'b1, idle_st});
        dir_rows.push_back('{CMD_END,     8'h00, 1'b1, idle_st});
        dir_rows.push_back('{CMD_NEXT,    8'h00, 1'b1, idle_st});
        dir_rows.push_back('{CMD_PRIOR,   8'h00, 1'b1, idle_st});
        dir_rows.push_back('{CMD_CLEAR,   8'h00, 1'b1,
            mk_status(1'b1, 8'h00, CURSOR_NONE, 0, 1'b1, 1'b0, 0, 0, 0, 0)});
        dir_rows.push_back('{CMD_INSERT,  CHR_A, 1'b1,
            mk_status(1'b1, CHR_A, 9'd0, 1, 1'b0, 1'b0, 1, 0, 0, 0)});
        dir_rows.push_back('{CMD_INSERT,  8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_INSERT,  8'hFF, 1'b0, '0});
        dir_rows.push_back('{CMD_INSERT,  CHR_T, 1'b0, '0});
        dir_rows.push_back('{CMD_PRIOR,   8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_START,   8'h00, 1'b0, '0});
        // prior at the first item is refused
        dir_rows.push_back('{CMD_PRIOR,   8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_END,     8'h00, 1'b0, '0});
        // next at the last item is refused
        dir_rows.push_back('{CMD_NEXT,    8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_REPLACE, CHR_G, 1'b0, '0});
        // remove on the last item steps the cursor back
        dir_rows.push_back('{CMD_REMOVE,  8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_START,   8'h00, 1'b0, '0});
        // remove elsewhere moves the last item into the cursor slot
        dir_rows.push_back('{CMD_REMOVE,  8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_READ,    8'h00, 1'b0, '0});
        dir_rows.push_back('{CMD_UNUSED_LO, 8'hAA, 1'b0, '0});
        dir_rows.push_back('{CMD_UNUSED_HI, 8'h55, 1'b0, '0});
        dir_rows.push_back('{CMD_REPLACE, CHR_C, 1'b0, '0});
        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].status);

        // Full capacity, no idling
        run_random(300, 35);

        // Single-item list, sender gaps
        set_capacity(1);
        src_idle_pct = 47;
        run_random(150, 40);

        // Small list, receiver stalls
        set_capacity(8);
        src_idle_pct   = 0;
        sink_stall_pct = 47;
        run_random(250, 40);

        // Zero capacity: always full
        set_capacity(0);
        src_idle_pct   = 13;
        sink_stall_pct = 13;
        run_random(60, 50);

        // Fill the whole store, then lower the capacity below the count
        set_capacity(MAX_ITEMS);
        send_item(CMD_CLEAR, pick_char(), 1'b0, '0);
        src_idle_pct   = 47;
        sink_stall_pct = 0;
        for (int i = 0; i < MAX_ITEMS + 4; i++)
            send_item(CMD_INSERT, pick_char(), 1'b0, '0);
        set_capacity(5);
        src_idle_pct   = 13;
        sink_stall_pct = 13;
        run_random(200, 30);

        // Capacity above the store size; hold the receiver so the input backs up
        set_capacity(511);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        run_random(60, 60);
        drain_status();
        src_idle_pct   = 13;
        sink_stall_pct = 13;
        run_random(400, 35);

        drain_status();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
